FILE: rtl/core/afg_pkg.sv
`timescale 1ns / 1ps
// afg_pkg: shared widths, register map and types for the alternation flap guard
// no dependencies; imported by every afg module and the top level

package afg_pkg;

	localparam int HIST_DEPTH = 6;
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
	localparam int ID_W       = 32;
	localparam int TIME_W     = 48;
	localparam int CFG_W      = 16;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CFG_W-1:0] FIGHT_WINDOW_RST = 16'd1500;
	localparam logic [CFG_W-1:0] FREEZE_RST       = 16'd2000;

	typedef enum logic {
		REG_FIGHT_WINDOW = 1'b0,
		REG_FREEZE       = 1'b1
	} reg_idx_t;

	typedef logic [ID_W-1:0]                     id_t;
	typedef logic [TIME_W-1:0]                   time_t;
	typedef logic [HIST_DEPTH-1:0][ID_W-1:0]     id_hist_t;
	typedef logic [HIST_DEPTH-1:0][TIME_W-1:0]   time_hist_t;

	typedef struct packed {
		logic  fight;
		logic  frozen;
		time_t freeze_end_nxt;
	} verdict_t;

endpackage

FILE: rtl/core/alternation_flap_guard_unit.sv
`timescale 1ns / 1ps
// alternation_flap_guard_unit: top level of the focus flap guard
// depends on afg_pkg, afg_cfg, afg_history and afg_detect
// a demand in the input register moves its result to the output register when the output advances
// throughput: one demand per cycle unless stalled; history and freeze end load from the input register
// a stalled output holds its result while the input register still takes one more demand
// reset clears the valid flags, fill count and freeze end and loads register defaults

module alternation_flap_guard_unit
	import afg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [79:0]       s_tdata,  // requester_id [31:0], time_ms [79:32]
	input  logic [0:0]        s_tuser,  // is_owner [0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // swallow [0], fight_seen [1], zero [7:2]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic              valid_s1;
	id_t               id_s1;
	time_t             time_s1;
	logic              owner_s1;
	logic              advance;
	logic              proc;
	logic              push;
	logic [CFG_W-1:0]  fight_window;
	logic [CFG_W-1:0]  freeze_time;
	id_hist_t          hist_id;
	time_hist_t        hist_time;
	logic [FILL_W-1:0] fill;
	time_t             freeze_end_q;
	verdict_t          verdict;
	logic              out_valid_q;
	logic              swallow_q;
	logic              fight_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign proc     = valid_s1 && advance;
	assign push     = proc && !owner_s1;

	afg_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fight_window (fight_window),
		.freeze_time  (freeze_time)
	);

	afg_history u_history (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_id   (id_s1),
		.push_time (time_s1),
		.hist_id   (hist_id),
		.hist_time (hist_time),
		.fill      (fill)
	);

	afg_detect u_detect (
		.hist_id      (hist_id),
		.hist_time    (hist_time),
		.fill         (fill),
		.req_id       (id_s1),
		.now          (time_s1),
		.fight_window (fight_window),
		.freeze_time  (freeze_time),
		.freeze_end   (freeze_end_q),
		.verdict      (verdict)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			id_s1    <= s_tdata[ID_W-1:0];
			time_s1  <= s_tdata[ID_W+TIME_W-1:ID_W];
			owner_s1 <= s_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freeze_end_q <= '0;
		end else if (push && verdict.fight) begin
			freeze_end_q <= verdict.freeze_end_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			swallow_q <= !owner_s1 && (verdict.frozen || verdict.fight);
			fight_q   <= !owner_s1 && verdict.fight;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, fight_q, swallow_q};

	a_fight_swallows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("fight result without swallow");

	a_owner_passes: assert property (@(posedge clk) disable iff (!arst_n)
		proc && owner_s1 |=> m_tdata[1:0] == 2'b00)
		else $error("owner demand not passed through");

	a_freeze_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		push && verdict.fight |=> freeze_end_q >= $past(time_s1))
		else $error("freeze end set before the fight demand");

	a_owner_keeps_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(freeze_end_q))
		else $error("freeze end moved without a recorded demand");

endmodule

FILE: rtl/core/afg_cfg.sv
`timescale 1ns / 1ps
// afg_cfg: apb register file holding the fight window and freeze time
// depends on afg_pkg

module afg_cfg
	import afg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [CFG_W-1:0]  fight_window,
	output logic [CFG_W-1:0]  freeze_time
);

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fight_window <= FIGHT_WINDOW_RST;
			freeze_time  <= FREEZE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_FIGHT_WINDOW: fight_window <= pwdata[CFG_W-1:0];
				REG_FREEZE:       freeze_time  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FIGHT_WINDOW: prdata = APB_DW'(fight_window);
			REG_FREEZE:       prdata = APB_DW'(freeze_time);
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/afg_history.sv
`timescale 1ns / 1ps
// afg_history: shift line of recent demand ids and times with a fill count
// depends on afg_pkg; newest entry sits at the top index

module afg_history
	import afg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  id_t               push_id,
	input  time_t             push_time,
	output id_hist_t          hist_id,
	output time_hist_t        hist_time,
	output logic [FILL_W-1:0] fill
);

	id_hist_t          id_q;
	time_hist_t        time_q;
	logic [FILL_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				id_q[i]   <= id_q[i+1];
				time_q[i] <= time_q[i+1];
			end
			id_q[HIST_DEPTH-1]   <= push_id;
			time_q[HIST_DEPTH-1] <= push_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push && fill_q != FILL_W'(HIST_DEPTH)) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	assign hist_id   = id_q;
	assign hist_time = time_q;
	assign fill      = fill_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(HIST_DEPTH))
		else $error("history fill count beyond depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && fill_q != FILL_W'(HIST_DEPTH) |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("history fill count missed a push");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(fill_q))
		else $error("history fill count moved without a push");

endmodule

FILE: rtl/core/afg_detect.sv
`timescale 1ns / 1ps
// afg_detect: fight detection, freeze test and new freeze end for one demand
// depends on afg_pkg; looks at the history as it stands after this demand

module afg_detect
	import afg_pkg::*;
(
	input  id_hist_t          hist_id,
	input  time_hist_t        hist_time,
	input  logic [FILL_W-1:0] fill,
	input  id_t               req_id,
	input  time_t             now,
	input  logic [CFG_W-1:0]  fight_window,
	input  logic [CFG_W-1:0]  freeze_time,
	input  time_t             freeze_end,
	output verdict_t          verdict
);

	id_hist_t          id_view;
	logic              full_view;
	logic [TIME_W:0]   span;
	logic              span_short;
	logic              alt_ok;
	logic [TIME_W:0]   end_sum;

	always_comb begin
		for (int i = 0; i < HIST_DEPTH - 1; i++) begin
			id_view[i] = hist_id[i+1];
		end
		id_view[HIST_DEPTH-1] = req_id;
	end

	assign full_view = (fill >= FILL_W'(HIST_DEPTH - 1));

	// oldest entry after the shift is hist_time[1]
	assign span       = {1'b0, now} - {1'b0, hist_time[1]};
	assign span_short = span[TIME_W] || (span[TIME_W-1:0] < TIME_W'(fight_window));

	always_comb begin
		alt_ok = (id_view[0] != id_view[1]);
		for (int i = 2; i < HIST_DEPTH; i++) begin
			if (id_view[i] != id_view[i-2]) begin
				alt_ok = 1'b0;
			end
		end
	end

	assign end_sum = {1'b0, now} + (TIME_W+1)'(freeze_time);

	assign verdict.fight          = full_view & span_short & alt_ok;
	assign verdict.frozen         = (now < freeze_end);
	assign verdict.freeze_end_nxt = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: directed and random focus demands for alternation_flap_guard_unit; known probe
// rows check a fixed verdict, others a bench model of id/time history, fight and freeze end
// depends on afg_pkg and the rtl top alternation_flap_guard_unit

module testbench;
	import afg_pkg::*;

	localparam int    CYCLE_LIMIT     = 100000;
	localparam int    ITEMS_PER_PHASE = 205;
	localparam int    NUM_PHASES      = 6;
	localparam time_t TIME_MAX        = '1;

	typedef struct packed {
		logic fight_seen;
		logic swallow;
	} guard_result_t;

	localparam guard_result_t PASSED    = 2'b00;
	localparam guard_result_t FIGHT_CUT = 2'b11;

	typedef struct {
		id_t           id;
		logic          owner;
		time_t         time_ms;
		logic          known;
		guard_result_t typed;
	} demand_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [79:0]       s_tdata;  // requester_id [31:0], time_ms [79:32]
	logic [0:0]        s_tuser;  // is_owner [0]
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;  // swallow [0], fight_seen [1], zero [7:2]
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	alternation_flap_guard_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// guard model state
	id_t              hist_id[HIST_DEPTH]   = '{default: '0};
	time_t            hist_time[HIST_DEPTH] = '{default: '0};
	int               fill_cnt              = 0;
	time_t            freeze_end            = '0;
	logic [CFG_W-1:0] window_ms             = FIGHT_WINDOW_RST;
	logic [CFG_W-1:0] freeze_len            = FREEZE_RST;

	demand_t       demand_q[$];
	guard_result_t verdict_q[$];
	demand_t       cur;
	time_t         now_ms      = '0;
	int            idle_pct    = 34;
	int            fail_cnt    = 0;
	int            demand_cnt  = 0;
	int            owner_cnt   = 0;
	int            fight_cnt   = 0;
	int            swallow_cnt = 0;
	int            cycle_cnt   = 0;

	demand_t probe_rows[26] = '{
		'{32'hFFFF_FFFF, 1'b1, 48'd0,    1'b1, PASSED},
		'{32'd1,         1'b0, 48'd0,    1'b1, PASSED},
		'{32'hFFFF_FFFF, 1'b0, 48'd100,  1'b1, PASSED},
		'{32'd1,         1'b0, 48'd200,  1'b1, PASSED},
		'{32'hFFFF_FFFF, 1'b0, 48'd300,  1'b1, PASSED},
		'{32'd1,         1'b0, 48'd400,  1'b1, PASSED},
		'{32'hFFFF_FFFF, 1'b0, 48'd500,  1'b0, PASSED},
		'{32'd2,         1'b1, 48'd600,  1'b1, PASSED},
		'{32'd3,         1'b0, 48'd700,  1'b0, PASSED},
		'{32'd1,         1'b0, 48'd2499, 1'b0, PASSED},
		'{32'd1,         1'b0, 48'd2500, 1'b0, PASSED},
		// span equal to the window, then one shorter
		'{32'd5,         1'b0, 48'd3000, 1'b0, PASSED},
		'{32'd6,         1'b0, 48'd3300, 1'b0, PASSED},
		'{32'd5,         1'b0, 48'd3600, 1'b0, PASSED},
		'{32'd6,         1'b0, 48'd3900, 1'b0, PASSED},
		'{32'd5,         1'b0, 48'd4200, 1'b0, PASSED},
		'{32'd6,         1'b0, 48'd4500, 1'b0, PASSED},
		'{32'd5,         1'b0, 48'd4799, 1'b0, PASSED},
		// time going backwards
		'{32'd6,         1'b0, 48'd100,  1'b0, PASSED},
		// freeze end saturates at the top of the time range
		'{32'd5,         1'b0, TIME_MAX - 48'd5, 1'b0, PASSED},
		'{32'd6,         1'b0, TIME_MAX - 48'd4, 1'b0, PASSED},
		'{32'd5,         1'b0, TIME_MAX - 48'd3, 1'b0, PASSED},
		'{32'd6,         1'b0, TIME_MAX - 48'd2, 1'b0, PASSED},
		'{32'd5,         1'b0, TIME_MAX - 48'd1, 1'b0, PASSED},
		'{32'd6,         1'b0, TIME_MAX,         1'b1, FIGHT_CUT},
		'{32'd7,         1'b0, TIME_MAX,         1'b0, PASSED}
	};

	function automatic guard_result_t judge_demand(input demand_t d);
		guard_result_t   r;
		logic [TIME_W:0] stretched;
		r = PASSED;
		if (d.owner)
			return r;
		if (fill_cnt < HIST_DEPTH) begin
			hist_id[fill_cnt]   = d.id;
			hist_time[fill_cnt] = d.time_ms;
			fill_cnt++;
		end else begin
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				hist_id[i]   = hist_id[i + 1];
				hist_time[i] = hist_time[i + 1];
			end
			hist_id[HIST_DEPTH - 1]   = d.id;
			hist_time[HIST_DEPTH - 1] = d.time_ms;
		end
		r.swallow    = d.time_ms < freeze_end;
		r.fight_seen = (fill_cnt == HIST_DEPTH) && (hist_id[0] != hist_id[1]);
		if (hist_time[HIST_DEPTH - 1] >= hist_time[0] &&
		    hist_time[HIST_DEPTH - 1] - hist_time[0] >= TIME_W'(window_ms))
			r.fight_seen = 1'b0;
		for (int i = 2; i < HIST_DEPTH; i++)
			if (hist_id[i] != hist_id[i % 2])
				r.fight_seen = 1'b0;
		if (r.fight_seen) begin
			stretched  = {1'b0, d.time_ms} + (TIME_W+1)'(freeze_len);
			freeze_end = stretched[TIME_W] ? TIME_MAX : stretched[TIME_W-1:0];
			r.swallow  = 1'b1;
		end
		return r;
	endfunction

	function automatic id_t pick_id();
		id_t v;
		v = ($urandom_range(0, 3) == 0) ? id_t'($urandom_range(1, 8)) : id_t'($urandom());
		return (v == '0) ? id_t'(1) : v;
	endfunction

	function automatic time_t advance_time(input int unsigned cap);
		logic [TIME_W:0] nxt;
		case ($urandom_range(0, 59))
			0: now_ms = time_t'({$urandom(), $urandom()});
			1: now_ms = (now_ms > 48'd3000) ?
			            now_ms - TIME_W'($urandom_range(0, 3000)) : now_ms;
			2: now_ms = TIME_MAX - TIME_W'($urandom_range(0, 40));
			default: begin
				nxt    = {1'b0, now_ms} + (TIME_W+1)'($urandom_range(0, cap));
				now_ms = nxt[TIME_W] ? TIME_MAX : nxt[TIME_W-1:0];
			end
		endcase
		return now_ms;
	endfunction

	function automatic void push_demand(input id_t id, input logic owner, input time_t t);
		demand_t d;
		d = '{id, owner, t, 1'b0, PASSED};
		demand_q.push_back(d);
	endfunction

	// two ids taking turns, with the odd owner demand or stray id mixed in
	function automatic int queue_fight_burst();
		id_t         first_id;
		id_t         second_id;
		int unsigned span_cap;
		int          len;
		int          n;
		first_id = pick_id();
		do
			second_id = pick_id();
		while (second_id == first_id);
		case ($urandom_range(0, 4))
			0: span_cap = 0;
			1: span_cap = 20;
			2: span_cap = 32'(window_ms) / 5;
			3: span_cap = 32'(window_ms) / 3;
			default: span_cap = 5000;
		endcase
		len = $urandom_range(3, 12);
		n   = 0;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_demand(pick_id(), 1'b1, advance_time(span_cap));
				n++;
			end
			if ($urandom_range(0, 19) == 0)
				push_demand(pick_id(), 1'b0, advance_time(span_cap));
			else
				push_demand((k % 2) ? second_id : first_id, 1'b0, advance_time(span_cap));
			n++;
		end
		return n;
	endfunction

	function automatic int queue_noise();
		push_demand(pick_id(), $urandom_range(0, 2) == 0, advance_time($urandom_range(0, 70000)));
		return 1;
	endfunction

	task automatic queue_phase();
		int queued;
		queued = 0;
		while (queued < ITEMS_PER_PHASE)
			queued += ($urandom_range(0, 9) < 7) ? queue_fight_burst() : queue_noise();
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (demand_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] readback;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'({$urandom(), value});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[CFG_W-1:0] !== value) begin
			$error("%s: expected %0d, got %0d", idx.name(), value, readback[CFG_W-1:0]);
			fail_cnt++;
		end
		if (idx == REG_FIGHT_WINDOW)
			window_ms = value;
		else
			freeze_len = value;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// demand source and model update on each input transfer
	always @(posedge clk) begin : feed_demands
		guard_result_t res;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				res = judge_demand(cur);
				verdict_q.push_back(cur.known ? cur.typed : res);
				demand_cnt++;
				owner_cnt += int'(cur.owner);
			end
			if (!s_tvalid || s_tready) begin
				if (demand_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur = demand_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur.time_ms, cur.id};
					s_tuser  <= cur.owner;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= idle_pct);
	end

	always @(posedge clk) begin : check_verdicts
		guard_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("result transfer with nothing expected, m_tdata %h", m_tdata);
				fail_cnt++;
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[0] !== want.swallow) begin
					$error("swallow: expected %0b, got %0b", want.swallow, m_tdata[0]);
					fail_cnt++;
				end
				if (m_tdata[1] !== want.fight_seen) begin
					$error("fight_seen: expected %0b, got %0b", want.fight_seen, m_tdata[1]);
					fail_cnt++;
				end
				fight_cnt   += int'(want.fight_seen);
				swallow_cnt += int'(want.swallow);
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] window_plan[NUM_PHASES];
		logic [CFG_W-1:0] freeze_plan[NUM_PHASES];
		window_plan = '{16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd700, 16'd1500};
		freeze_plan = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd900, 16'd2000};
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		arst_n   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (probe_rows[i])
			demand_q.push_back(probe_rows[i]);
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			if (p == 4) begin
				window_plan[p] = CFG_W'($urandom_range(1, 65535));
				freeze_plan[p] = CFG_W'($urandom_range(1, 65535));
			end
			write_register(REG_FIGHT_WINDOW, window_plan[p]);
			write_register(REG_FREEZE, freeze_plan[p]);
			@(negedge clk);
			idle_pct = (p == 2) ? 0 : 34;
			now_ms   = time_t'($urandom_range(0, 100000));
			queue_phase();
		end
		settle();
		repeat (4) @(posedge clk);
		$display("checked %0d demands (%0d from owners) over %0d register settings",
		         demand_cnt, owner_cnt, NUM_PHASES + 1);
		$display("%0d fights detected, %0d demands swallowed", fight_cnt, swallow_cnt);
		if (fail_cnt == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
